[src/sgs3d_pkg.sv]
// Shared types, constants and tap weight functions for the 3-D Savitzky-Golay smoother.
// No dependencies; imported by savitzky_golay_3d_smoother_core.
package sgs3d_pkg;

    typedef logic [15:0]       sample_t;
    typedef logic [5:0]        size_t;
    typedef logic [4:0]        pos_t;
    typedef logic [5:0]        coord_t;
    typedef logic [2:0]        tap_t;
    typedef logic [1:0]        status_t;
    typedef logic [1:0]        cfg_index_t;
    typedef logic signed [6:0] weight_t;

    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 24;
    localparam int ACC_W       = 29;
    localparam int DIV_W       = 25;
    localparam int QUOT_W      = 16;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 35;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam status_t STATUS_FILTERED     = 2'd0;
    localparam status_t STATUS_EDGE         = 2'd1;
    localparam status_t STATUS_OUT_OF_RANGE = 2'd2;

    localparam cfg_index_t REG_SIZE_X = 2'd0;
    localparam cfg_index_t REG_SIZE_Y = 2'd1;
    localparam cfg_index_t REG_SIZE_Z = 2'd2;

    localparam size_t SIZE_RESET = 6'd32;

    localparam tap_t TAP_LAST = 3'd4;
    localparam int   HALF_WIN = 2;

    localparam int WEIGHT_BASE = 37;
    localparam int WEIGHT_STEP = 5;
    localparam int WEIGHT_DEN  = 875;
    localparam int ONE_Q15     = 32768;
    localparam int ROUND_HALF  = WEIGHT_DEN / 2;
    localparam int CLIP_LIMIT  = (ONE_Q15 + 1) * WEIGHT_DEN - ROUND_HALF;

    // 2**35 / 875 rounded up; the product gives the exact quotient for dividends below 2**25.
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd39268273;

    function automatic logic [3:0] offset_sq(input tap_t d);
        logic [3:0] r;
        unique case (d)
            3'd0:    r = 4'd4;
            3'd1:    r = 4'd1;
            3'd2:    r = 4'd0;
            3'd3:    r = 4'd1;
            3'd4:    r = 4'd4;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic weight_t tap_weight(input tap_t dx, input tap_t dy, input tap_t dz);
        logic [3:0] s;
        s = offset_sq(dx) + offset_sq(dy) + offset_sq(dz);
        return weight_t'(7'(WEIGHT_BASE) - 7'(WEIGHT_STEP) * 7'(s));
    endfunction

endpackage

[src/savitzky_golay_3d_smoother_core.sv]
// Top level of the 3-D Savitzky-Golay smoother: volume memory, tap sequencer,
// multiply-accumulate and reciprocal-multiply division by 875. Depends on sgs3d_pkg.
//
// A store transaction writes one voxel. A read transaction returns one result:
// an out-of-range read goes straight to delivery, an edge read passes through a
// memory wait and a load state, and an interior read has an accept step, then
// 125 tap steps in which the single memory read port fetches one window voxel each,
// a pipeline drain, a rounding step, a reciprocal-multiply step and a delivery step;
// a sum that clips or is not positive skips the multiply. Delivery waits while the
// output register still holds an unaccepted result. The block takes no new
// transaction while a read is in progress, but a finished result waits in the output
// register while the next transaction is accepted. The volume holds MAX_X*MAX_Y*MAX_Z
// samples that are undefined until written and is never cleared.
module savitzky_golay_3d_smoother_core #(
    parameter int unsigned MAX_X = 32,
    parameter int unsigned MAX_Y = 32,
    parameter int unsigned MAX_Z = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  sgs3d_pkg::cfg_index_t  cfg_index,
    input  sgs3d_pkg::size_t       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  sgs3d_pkg::pos_t        s_pos_x,
    input  sgs3d_pkg::pos_t        s_pos_y,
    input  sgs3d_pkg::pos_t        s_pos_z,
    input  sgs3d_pkg::sample_t     s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sgs3d_pkg::sample_t     m_smoothed,
    output sgs3d_pkg::status_t     m_status
);
    import sgs3d_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM_X = (MAX_X < 63) ? MAX_X : 63;
    localparam int LIM_Y = (MAX_Y < 63) ? MAX_Y : 63;
    localparam int LIM_Z = (MAX_Z < 63) ? MAX_Z : 63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_ROUND,
        ST_DIVIDE,
        ST_PASS_WAIT,
        ST_PASS_LOAD,
        ST_DELIVER
    } state_t;

    function automatic logic [AW-1:0] vox_addr(input coord_t x, input coord_t y,
                                               input coord_t z);
        return (AW'(x) * AW'(MAX_Y) + AW'(y)) * AW'(MAX_Z) + AW'(z);
    endfunction

    sample_t volume_mem [DEPTH];

    state_t                   state_reg, state_next;
    size_t                    size_x_reg, size_x_next;
    size_t                    size_y_reg, size_y_next;
    size_t                    size_z_reg, size_z_next;
    pos_t                     x_reg, x_next;
    pos_t                     y_reg, y_next;
    pos_t                     z_reg, z_next;
    tap_t                     dx_reg, dx_next;
    tap_t                     dy_reg, dy_next;
    tap_t                     dz_reg, dz_next;
    logic [AW-1:0]            rd_addr_reg, rd_addr_next;
    sample_t                  rd_data_reg;
    weight_t                  w1_reg, w1_next;
    weight_t                  w2_reg, w2_next;
    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [DIV_W-1:0]         dividend_reg, dividend_next;
    sample_t                  res_value_reg, res_value_next;
    status_t                  res_status_reg, res_status_next;
    logic                     m_valid_reg, m_valid_next;
    sample_t                  m_smoothed_reg, m_smoothed_next;
    status_t                  m_status_reg, m_status_next;

    size_t                    eff_x, eff_y, eff_z;
    logic                     in_range, on_edge, accept, mem_wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  round_sum;
    logic [DIV_W+RECIP_W-1:0] recip_prod;

    assign eff_x = (size_x_reg > 6'(LIM_X)) ? 6'(LIM_X) : size_x_reg;
    assign eff_y = (size_y_reg > 6'(LIM_Y)) ? 6'(LIM_Y) : size_y_reg;
    assign eff_z = (size_z_reg > 6'(LIM_Z)) ? 6'(LIM_Z) : size_z_reg;

    assign in_range = ({1'b0, s_pos_x} < eff_x) && ({1'b0, s_pos_y} < eff_y)
                   && ({1'b0, s_pos_z} < eff_z);
    assign on_edge  = (s_pos_x < 5'(HALF_WIN)) || ({2'b0, s_pos_x} + 7'(HALF_WIN) >= {1'b0, eff_x})
                   || (s_pos_y < 5'(HALF_WIN)) || ({2'b0, s_pos_y} + 7'(HALF_WIN) >= {1'b0, eff_y})
                   || (s_pos_z < 5'(HALF_WIN)) || ({2'b0, s_pos_z} + 7'(HALF_WIN) >= {1'b0, eff_z});

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign mem_wr_en = accept && (s_func == FUNC_STORE) && in_range;
    assign wr_addr   = vox_addr({1'b0, s_pos_x}, {1'b0, s_pos_y}, {1'b0, s_pos_z});

    assign product    = w2_reg * $signed({1'b0, rd_data_reg});
    assign round_sum  = acc_reg + ACC_W'(ROUND_HALF);
    assign recip_prod = dividend_reg * RECIP_MUL;

    assign m_valid    = m_valid_reg;
    assign m_smoothed = m_smoothed_reg;
    assign m_status   = m_status_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            volume_mem[wr_addr] <= s_sample;
        end
        rd_data_reg <= volume_mem[rd_addr_reg];
    end

    always_comb begin
        state_next      = state_reg;
        size_x_next     = size_x_reg;
        size_y_next     = size_y_reg;
        size_z_next     = size_z_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        dz_next         = dz_reg;
        rd_addr_next    = rd_addr_reg;
        w1_next         = w1_reg;
        w2_next         = w1_reg;
        v1_next         = 1'b0;
        v2_next         = v1_reg;
        acc_next        = v2_reg ? acc_reg + ACC_W'(product) : acc_reg;
        dividend_next   = dividend_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_smoothed_next = m_smoothed_reg;
        m_status_next   = m_status_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIZE_X: size_x_next = cfg_wdata;
                REG_SIZE_Y: size_y_next = cfg_wdata;
                REG_SIZE_Z: size_z_next = cfg_wdata;
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_func == FUNC_READ) begin
                    x_next = s_pos_x;
                    y_next = s_pos_y;
                    z_next = s_pos_z;
                    if (!in_range) begin
                        res_value_next  = '0;
                        res_status_next = STATUS_OUT_OF_RANGE;
                        state_next      = ST_DELIVER;
                    end else if (on_edge) begin
                        rd_addr_next = wr_addr;
                        state_next   = ST_PASS_WAIT;
                    end else begin
                        dx_next    = '0;
                        dy_next    = '0;
                        dz_next    = '0;
                        acc_next   = '0;
                        state_next = ST_TAPS;
                    end
                end
            end
            ST_TAPS: begin
                rd_addr_next = vox_addr(6'(x_reg) + 6'(dx_reg) - 6'(HALF_WIN),
                                        6'(y_reg) + 6'(dy_reg) - 6'(HALF_WIN),
                                        6'(z_reg) + 6'(dz_reg) - 6'(HALF_WIN));
                w1_next = tap_weight(dx_reg, dy_reg, dz_reg);
                v1_next = 1'b1;
                if (dz_reg != TAP_LAST) begin
                    dz_next = dz_reg + 3'd1;
                end else begin
                    dz_next = '0;
                    if (dy_reg != TAP_LAST) begin
                        dy_next = dy_reg + 3'd1;
                    end else begin
                        dy_next = '0;
                        if (dx_reg != TAP_LAST) begin
                            dx_next = dx_reg + 3'd1;
                        end else begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                res_status_next = STATUS_FILTERED;
                if (acc_reg <= $signed(ACC_W'(0))) begin
                    res_value_next = '0;
                    state_next     = ST_DELIVER;
                end else if (acc_reg >= $signed(ACC_W'(CLIP_LIMIT))) begin
                    res_value_next = SAMPLE_W'(ONE_Q15);
                    state_next     = ST_DELIVER;
                end else begin
                    dividend_next = round_sum[DIV_W-1:0];
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                res_value_next = recip_prod[RECIP_SHIFT +: QUOT_W];
                state_next     = ST_DELIVER;
            end
            ST_PASS_WAIT: begin
                state_next = ST_PASS_LOAD;
            end
            ST_PASS_LOAD: begin
                res_value_next  = rd_data_reg;
                res_status_next = STATUS_EDGE;
                state_next      = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_smoothed_next = res_value_reg;
                    m_status_next   = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_x_reg  <= SIZE_RESET;
            size_y_reg  <= SIZE_RESET;
            size_z_reg  <= SIZE_RESET;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_x_reg  <= size_x_next;
            size_y_reg  <= size_y_next;
            size_z_reg  <= size_z_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dz_reg         <= dz_next;
        rd_addr_reg    <= rd_addr_next;
        w1_reg         <= w1_next;
        w2_reg         <= w2_next;
        acc_reg        <= acc_next;
        dividend_reg   <= dividend_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_smoothed_reg <= m_smoothed_next;
        m_status_reg   <= m_status_next;
    end

    // The tap pipeline must be empty whenever a new transaction can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!v1_reg && !v2_reg))
        else $error("tap pipeline busy while idle");

    // The dividend stays below the clipping bound plus the rounding half, where the reciprocal product is exact.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (dividend_reg < DIV_W'(CLIP_LIMIT + ROUND_HALF)))
        else $error("divider input out of bounds");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_FILTERED)
            |-> (m_smoothed_reg <= SAMPLE_W'(ONE_Q15)))
        else $error("filtered result above one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_OUT_OF_RANGE) |-> (m_smoothed_reg == '0))
        else $error("out-of-range result not zero");

endmodule
